/* design/rita_pkg.sv */
// Shared widths, constants and digit encoding for the radix integer-to-ASCII unit.
package rita_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int IN_WIDTH    = 32;
  localparam int QW          = (VALUE_WIDTH < IN_WIDTH) ? VALUE_WIDTH : IN_WIDTH;
  localparam int CW          = $clog2(QW + 1);
  localparam int AW          = $clog2(QW);
  localparam int RW          = 6;
  localparam int CHW         = 7;

  localparam logic [RW-1:0]  RADIX_MIN = RW'(2);
  localparam logic [RW-1:0]  RADIX_MAX = RW'(36);
  localparam logic [RW-1:0]  NUM_DEC   = RW'(10);
  localparam logic [CHW-1:0] CHAR_ZERO = CHW'(48);
  localparam logic [CHW-1:0] CHAR_A    = CHW'(65);

  typedef logic [QW-1:0] quot_t;
  typedef logic [RW-1:0] digit_t;

  function automatic logic [CHW-1:0] to_ascii(input digit_t d);
    logic [CHW-1:0] c;
    if (d < NUM_DEC) begin
      c = CHAR_ZERO + CHW'(d);
    end else if (d < RADIX_MAX) begin
      c = CHAR_A + CHW'(d - NUM_DEC);
    end else begin
      c = CHAR_ZERO;
    end
    return c;
  endfunction

  function automatic digit_t sat_radix(input digit_t r);
    digit_t s;
    if (r < RADIX_MIN) begin
      s = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      s = RADIX_MAX;
    end else begin
      s = r;
    end
    return s;
  endfunction

endpackage

/* design/rita_divider.sv */
// Restoring bit-serial divider: one quotient bit per cycle.
module rita_divider
  import rita_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  quot_t  dividend,
  input  digit_t divisor,
  output logic   done,
  output quot_t  quotient,
  output digit_t remainder
);

  quot_t       q;
  digit_t      rem;
  digit_t      dvs;
  logic [CW-1:0] cnt;
  logic        busy;

  logic [RW:0] rem_sh;
  logic [RW:0] diff;
  logic        ge;

  assign rem_sh = {rem, q[QW-1]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      q   <= {q[QW-2:0], ge};
      rem <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
    end
  end

  assign quotient  = q;
  assign remainder = rem;

endmodule

/* design/rita_digit_store.sv */
// Digit store: one write port, one registered read port.
module rita_digit_store
  import rita_pkg::*;
(
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  digit_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output digit_t        rdata
);

  digit_t mem [QW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/radix_integer_to_ascii_unit.sv */
// Top level: sequencer for the radix integer-to-ASCII unit.
//
// Request channel (req_valid / req_stall) takes one word: value and radix.
// Radix below 2 is used as 2, above 36 as 36. Response channel
// (rsp_valid / rsp_stall) returns one word per digit: digit_char in ASCII
// ('0'-'9', 'A'-'Z'), most significant digit first, last set on the final
// digit. A value of zero gives the single digit '0'.
// One request is worked on at a time; req_stall is high from acceptance
// until the final digit has been taken.
// Each digit comes from the shared bit-serial divider (one quotient bit per
// cycle, after loading it); once all digits are stored, each one is read
// from the digit store (S_READ) and then presented (S_OUT).
// While rsp_stall is high the digit word holds and the unit waits.
// Reset (rst, synchronous) returns the sequencer to idle and drops any
// request in progress; the digit store needs no clearing.
module radix_integer_to_ascii_unit
  import rita_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  logic [31:0]    value,
  input  logic [5:0]     radix,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output logic [CHW-1:0] digit_char,
  output logic           last
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_READ = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t        state, state_next;
  digit_t        radix_r;
  logic [CW-1:0] count;
  logic [AW-1:0] ptr;

  logic   req_acc;
  logic   rsp_acc;
  logic   div_start;
  logic   div_done;
  quot_t  div_dividend;
  digit_t div_divisor;
  quot_t  div_q;
  digit_t div_rem;
  logic   finish;
  digit_t rd_data;

  assign req_acc   = req_valid && !req_stall;
  assign rsp_acc   = rsp_valid && !rsp_stall;
  assign req_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_OUT);
  assign finish    = (div_q == '0) || (count == CW'(QW - 1));

  assign div_start    = req_acc || (div_done && !finish);
  assign div_dividend = (state == S_IDLE) ? value[QW-1:0] : div_q;
  assign div_divisor  = (state == S_IDLE) ? sat_radix(radix) : radix_r;

  rita_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  rita_digit_store u_store (
    .clk   (clk),
    .we    (div_done),
    .waddr (count[AW-1:0]),
    .wdata (div_rem),
    .re    (state == S_READ),
    .raddr (ptr),
    .rdata (rd_data)
  );

  assign digit_char = to_ascii(rd_data);
  assign last       = (ptr == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_acc) state_next = S_DIV;
      S_DIV:  if (div_done && finish) state_next = S_READ;
      S_READ: state_next = S_OUT;
      S_OUT: begin
        if (rsp_acc) state_next = last ? S_IDLE : S_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ptr   <= '0;
    end else begin
      state <= state_next;
      if (req_acc) begin
        count <= '0;
      end else if (div_done) begin
        count <= count + CW'(1);
        if (finish) ptr <= count[AW-1:0];
      end else if (rsp_acc && !last) begin
        ptr <= ptr - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) radix_r <= sat_radix(radix);
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider done outside division phase");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QW))
    else $error("digit count beyond store depth");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> req_stall && !rsp_valid)
    else $error("request not held off after acceptance");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_acc && last) |=> !req_stall)
    else $error("unit not idle after final digit");

  a_ptr_in_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> CW'(ptr) < count)
    else $error("read pointer outside stored digits");

endmodule
